### design/hashed_object_dictionary_table_macros.svh
// Assertion macros shared by the checker of the object dictionary table.
// Needs nothing else; include by bare file name.
`ifndef HASHED_OBJECT_DICTIONARY_TABLE_MACROS_SVH
`define HASHED_OBJECT_DICTIONARY_TABLE_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define HODT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("hodt assertion failed");

// Next-cycle implication, off while reset is asserted.
`define HODT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("hodt assertion failed");

`endif

### design/hodt_pkg.sv
// Shared constants, codes and types of the object dictionary table.
// No dependencies; the design and checker files refer to it by scoped names.
package hodt_pkg;

  // Storage sizes
  localparam int SLOTS         = 256;
  localparam int PERSIST_SLOTS = 32;
  localparam int SLOT_W        = $clog2(SLOTS);
  localparam int PIDX_W        = (PERSIST_SLOTS > 1) ? $clog2(PERSIST_SLOTS) : 1;

  // Persistent-list scan: lanes checked per cycle
  localparam int SCAN_LANES  = 8;
  localparam int SCAN_GROUPS = (PERSIST_SLOTS + SCAN_LANES - 1) / SCAN_LANES;
  localparam int GRP_W       = (SCAN_GROUPS > 1) ? $clog2(SCAN_GROUPS) : 1;

  // Field widths
  localparam int IDX_W   = 16;
  localparam int SUB_W   = 8;
  localparam int DTYPE_W = 16;
  localparam int ACC_W   = 8;
  localparam int PERS_W  = 8;
  localparam int VAL_W   = 32;

  // Hash index*31 + subindex fits 21 bits; reduced 3 bits per step
  localparam int HASH_W    = 21;
  localparam int DIV_BITS  = 3;
  localparam int DIV_STEPS = HASH_W / DIV_BITS;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // Configuration register widths and reset values
  localparam int MOD_W  = 9;
  localparam int CNT_W  = 6;
  localparam int CODE_W = 8;
  localparam logic [MOD_W-1:0]  SLOT_COUNT_RST      = 9'd256;
  localparam logic [CNT_W-1:0]  PERSIST_COUNT_RST   = 6'd32;
  localparam logic [CODE_W-1:0] PERSISTENT_CODE_RST = 8'd1;

  typedef enum logic [1:0] {
    REG_SLOT_COUNT      = 2'd0,
    REG_PERSIST_COUNT   = 2'd1,
    REG_PERSISTENT_CODE = 2'd2
  } reg_e;

  typedef enum logic [1:0] {
    KIND_INSERT    = 2'd0,
    KIND_LOOKUP    = 2'd1,
    KIND_SET_VALUE = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    STAT_NEW         = 3'd0,
    STAT_OVERWRITTEN = 3'd1,
    STAT_COLLISION   = 3'd2,
    STAT_FOUND       = 3'd3,
    STAT_NOT_PRESENT = 3'd4,
    STAT_UPDATED     = 3'd5
  } status_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic [IDX_W-1:0]   obj_index;
    logic [SUB_W-1:0]   sub_index;
    logic [DTYPE_W-1:0] data_type;
    logic [ACC_W-1:0]   access_mode;
    logic [PERS_W-1:0]  persistence;
    logic [VAL_W-1:0]   data_value;
  } req_t;

  typedef struct packed {
    logic               valid;
    logic [IDX_W-1:0]   obj_index;
    logic [SUB_W-1:0]   sub_index;
    logic [DTYPE_W-1:0] data_type;
    logic [ACC_W-1:0]   access_mode;
    logic [PERS_W-1:0]  persistence;
    logic [VAL_W-1:0]   data_value;
  } entry_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [7:0]         slot;
    logic [IDX_W-1:0]   found_index;
    logic [SUB_W-1:0]   found_subindex;
    logic [DTYPE_W-1:0] found_data_type;
    logic [ACC_W-1:0]   found_access;
    logic [PERS_W-1:0]  found_persistence;
    logic [VAL_W-1:0]   found_value;
    logic               persist_recorded;
  } res_t;

endpackage

### design/hashed_object_dictionary_table.sv
// Top level of the direct-mapped object dictionary table with APB setup port.
// Depends on hodt_pkg and hodt_slot_hash.
//
// Each request (insert, lookup or set value) hashes its key to the slot
// (index*31 + subindex) mod the table size and answers with exactly one result.
// A request goes from acceptance to result through the shared modulo unit,
// which folds 3 bits of the 21-bit hash into the remainder per cycle, then
// the sequencer state that sees the unit finish, the registered slot-memory
// read, and the slot update that also loads the output register. The next
// request can be taken in the cycle after the result is loaded; a result still
// held in the output register stalls the next commit. The persistent-id list
// is searched 8 entries per cycle alongside the modulo steps; it holds at most
// 32 entries, so it ends no later than the modulo unit and adds no time. One
// request is in flight at a time; the next may be taken while the previous
// result still waits in the output register. After reset the slot memory is
// cleared one slot per cycle, all 256 slots, during which no request is taken
// (setup writes still are). Only the free flag of each persistent-list entry
// is kept, since stored ids are never read back; an id of zero leaves its
// entry free.
module hashed_object_dictionary_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB setup port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // obj_index[15:0], sub_index[23:16], data_type[39:24], access_mode[47:40],
  // persistence[55:48], data_value[87:56]
  input  logic [87:0] s_axis_tdata,
  // kind[1:0]
  input  logic [1:0]  s_axis_tuser,
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // slot[7:0], found_index[23:8], found_subindex[31:24], found_data_type[47:32],
  // found_access[55:48], found_persistence[63:56], found_value[95:64],
  // persist_recorded[96], zero[103:97]
  output logic [103:0] m_axis_tdata,
  // status[2:0]
  output logic [2:0]  m_axis_tuser
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIVIDE,
    S_READ,
    S_COMMIT
  } state_e;

  state_e state_q;

  // Setup registers
  logic [hodt_pkg::MOD_W-1:0]  tsize_q;
  logic [hodt_pkg::CNT_W-1:0]  pcount_q;
  logic [hodt_pkg::CODE_W-1:0] pcode_q;
  logic                        cfg_wr;

  // Request, result and memory signals
  hodt_pkg::req_t   req_q;
  hodt_pkg::res_t   res_d, out_q;
  logic             out_valid_q, out_free, accept;
  hodt_pkg::entry_t mem [hodt_pkg::SLOTS];
  hodt_pkg::entry_t rd_q, mem_wdata;
  logic             mem_we;
  logic [hodt_pkg::SLOT_W-1:0] mem_waddr, slot_idx, clr_q;

  // Hash unit
  logic [hodt_pkg::MOD_W-1:0] m_eff, hash_rem;
  logic                       hash_busy;

  // Persistent-list scan
  logic [hodt_pkg::PERSIST_SLOTS-1:0] free_q;
  logic [hodt_pkg::GRP_W-1:0]         grp_q;
  logic                               scan_busy_q, hit_q, grp_hit, free_clr;
  logic [hodt_pkg::PIDX_W-1:0]        hit_idx_q, grp_idx;
  logic [8:0]                         n_eff;

  // ---------------- APB setup port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[3:2])
      hodt_pkg::REG_SLOT_COUNT:      prdata = 32'(tsize_q);
      hodt_pkg::REG_PERSIST_COUNT:   prdata = 32'(pcount_q);
      hodt_pkg::REG_PERSISTENT_CODE: prdata = 32'(pcode_q);
      default:                       prdata = '0;
    endcase
  end

  // Effective modulus: zero acts as one, above SLOTS acts as SLOTS
  always_comb begin
    if ({4'b0000, tsize_q} > 13'(hodt_pkg::SLOTS)) begin
      m_eff = hodt_pkg::MOD_W'(hodt_pkg::SLOTS);
    end else begin
      m_eff = tsize_q;
    end
    if (m_eff == '0) begin
      m_eff = hodt_pkg::MOD_W'(1);
    end
  end

  // Effective list length, clamped to the list storage
  assign n_eff = ({3'b000, pcount_q} > 9'(hodt_pkg::PERSIST_SLOTS)) ?
                 9'(hodt_pkg::PERSIST_SLOTS) : {3'b000, pcount_q};

  // ---------------- request side ----------------
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  hodt_slot_hash u_slot_hash (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept),
    .obj_index_i (s_axis_tdata[15:0]),
    .sub_index_i (s_axis_tdata[23:16]),
    .modulus_i   (m_eff),
    .busy_o      (hash_busy),
    .rem_o       (hash_rem)
  );

  assign slot_idx = hodt_pkg::SLOT_W'(hash_rem);

  // Find the first free list entry within the current group of lanes
  always_comb begin
    int e;
    grp_hit = 1'b0;
    grp_idx = '0;
    e       = 0;
    for (int k = hodt_pkg::SCAN_LANES - 1; k >= 0; k--) begin
      e = int'(grp_q) * hodt_pkg::SCAN_LANES + k;
      if (e < hodt_pkg::PERSIST_SLOTS && e < int'(n_eff) &&
          free_q[hodt_pkg::PIDX_W'(e)]) begin
        grp_hit = 1'b1;
        grp_idx = hodt_pkg::PIDX_W'(e);
      end
    end
  end

  // ---------------- slot update and result ----------------
  always_comb begin
    res_d           = '0;
    res_d.slot      = 8'(hash_rem);
    res_d.status    = hodt_pkg::STAT_NOT_PRESENT;
    mem_we          = 1'b0;
    mem_waddr       = slot_idx;
    mem_wdata       = rd_q;
    free_clr        = 1'b0;
    if (state_q == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else if (state_q == S_COMMIT && out_free) begin
      unique case (req_q.kind)
        hodt_pkg::KIND_INSERT: begin
          if (rd_q.valid && rd_q.obj_index != req_q.obj_index) begin
            res_d.status = hodt_pkg::STAT_COLLISION;
          end else begin
            res_d.status = rd_q.valid ? hodt_pkg::STAT_OVERWRITTEN : hodt_pkg::STAT_NEW;
            mem_we                = 1'b1;
            mem_wdata.valid       = 1'b1;
            mem_wdata.obj_index   = req_q.obj_index;
            mem_wdata.sub_index   = req_q.sub_index;
            mem_wdata.data_type   = req_q.data_type;
            mem_wdata.access_mode = req_q.access_mode;
            mem_wdata.persistence = req_q.persistence;
            mem_wdata.data_value  = req_q.data_value;
            // Record the id; an id of zero leaves the entry free
            if (req_q.persistence == pcode_q && hit_q) begin
              res_d.persist_recorded = 1'b1;
              free_clr = ({req_q.obj_index, req_q.sub_index} != '0);
            end
          end
        end
        hodt_pkg::KIND_LOOKUP: begin
          if (rd_q.valid) begin
            res_d.status            = hodt_pkg::STAT_FOUND;
            res_d.found_index       = rd_q.obj_index;
            res_d.found_subindex    = rd_q.sub_index;
            res_d.found_data_type   = rd_q.data_type;
            res_d.found_access      = rd_q.access_mode;
            res_d.found_persistence = rd_q.persistence;
            res_d.found_value       = rd_q.data_value;
          end
        end
        hodt_pkg::KIND_SET_VALUE: begin
          if (rd_q.valid) begin
            res_d.status         = hodt_pkg::STAT_UPDATED;
            mem_we               = 1'b1;
            mem_wdata.data_value = req_q.data_value;
          end
        end
        default: begin
          res_d.status = hodt_pkg::STAT_NOT_PRESENT;
        end
      endcase
    end
  end

  // Slot memory: one write port, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[slot_idx];
  end

  // Request payload holds for the whole operation
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= {s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[23:16],
                s_axis_tdata[39:24], s_axis_tdata[47:40], s_axis_tdata[55:48],
                s_axis_tdata[87:56]};
    end
    if (state_q == S_COMMIT && out_free) begin
      out_q <= res_d;
    end
    if (scan_busy_q && grp_hit && !hit_q) begin
      hit_idx_q <= grp_idx;
    end
  end

  // Sequencer, setup registers, list flags and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      tsize_q     <= hodt_pkg::SLOT_COUNT_RST;
      pcount_q    <= hodt_pkg::PERSIST_COUNT_RST;
      pcode_q     <= hodt_pkg::PERSISTENT_CODE_RST;
      out_valid_q <= 1'b0;
      free_q      <= '1;
      grp_q       <= '0;
      scan_busy_q <= 1'b0;
      hit_q       <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[3:2])
          hodt_pkg::REG_SLOT_COUNT:      tsize_q  <= pwdata[hodt_pkg::MOD_W-1:0];
          hodt_pkg::REG_PERSIST_COUNT:   pcount_q <= pwdata[hodt_pkg::CNT_W-1:0];
          hodt_pkg::REG_PERSISTENT_CODE: pcode_q  <= pwdata[hodt_pkg::CODE_W-1:0];
          default: ;
        endcase
      end

      // Load a new result, or drop the one just taken
      if (state_q == S_COMMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      // Advance the list scan one lane group per cycle, stop at the first hit
      if (accept) begin
        grp_q       <= '0;
        scan_busy_q <= 1'b1;
        hit_q       <= 1'b0;
      end else if (scan_busy_q) begin
        grp_q <= grp_q + 1'b1;
        if (grp_hit) begin
          hit_q       <= 1'b1;
          scan_busy_q <= 1'b0;
        end else if (grp_q == hodt_pkg::GRP_W'(hodt_pkg::SCAN_GROUPS - 1)) begin
          scan_busy_q <= 1'b0;
        end
      end

      if (free_clr) begin
        free_q[hit_idx_q] <= 1'b0;
      end

      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == hodt_pkg::SLOT_W'(hodt_pkg::SLOTS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state_q <= S_DIVIDE;
          end
        end
        S_DIVIDE: begin
          if (!hash_busy && !scan_busy_q) begin
            state_q <= S_READ;
          end
        end
        S_READ: begin
          state_q <= S_COMMIT;
        end
        S_COMMIT: begin
          // Hold until the output register is free
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {7'b0000000, out_q.persist_recorded, out_q.found_value,
                          out_q.found_persistence, out_q.found_access,
                          out_q.found_data_type, out_q.found_subindex,
                          out_q.found_index, out_q.slot};

endmodule

### design/hodt_slot_hash.sv
// Iterative slot hash: (index*31 + subindex) mod modulus, a few bits a step.
// Depends on hodt_pkg.
module hodt_slot_hash (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [hodt_pkg::IDX_W-1:0]  obj_index_i,
  input  logic [hodt_pkg::SUB_W-1:0]  sub_index_i,
  input  logic [hodt_pkg::MOD_W-1:0]  modulus_i,
  output logic                        busy_o,
  output logic [hodt_pkg::MOD_W-1:0]  rem_o
);

  logic [hodt_pkg::HASH_W-1:0] dividend_q, dividend_d, hash;
  logic [hodt_pkg::MOD_W-1:0]  rem_q, rem_d;
  logic [hodt_pkg::STEP_W-1:0] step_q;
  logic                        busy_q;
  logic [hodt_pkg::MOD_W:0]    r;

  // index*31 as index*32 - index
  assign hash = {obj_index_i, 5'b00000} - hodt_pkg::HASH_W'(obj_index_i)
              + hodt_pkg::HASH_W'(sub_index_i);

  // Shift in the next dividend bits and keep the partial remainder below the modulus
  always_comb begin
    r = {1'b0, rem_q};
    for (int b = 0; b < hodt_pkg::DIV_BITS; b++) begin
      r = {r[hodt_pkg::MOD_W-1:0], dividend_q[hodt_pkg::HASH_W-1-b]};
      if (r >= {1'b0, modulus_i}) begin
        r = r - {1'b0, modulus_i};
      end
    end
    rem_d      = r[hodt_pkg::MOD_W-1:0];
    dividend_d = dividend_q << hodt_pkg::DIV_BITS;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + 1'b1;
      if (step_q == hodt_pkg::STEP_W'(hodt_pkg::DIV_STEPS - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dividend_q <= hash;
      rem_q      <= '0;
    end else if (busy_q) begin
      dividend_q <= dividend_d;
      rem_q      <= rem_d;
    end
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

### design/hodt_checker.sv
// Port-level checks of the object dictionary table, bound to the top level.
// Depends on hodt_pkg and hashed_object_dictionary_table_macros.svh.
`include "hashed_object_dictionary_table_macros.svh"

module hodt_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [103:0] m_axis_tdata,
  input logic [2:0]   m_axis_tuser
);

  // A stalled result stays put
  `HODT_ASSERT_NEXT(a_result_holds, clk_i, rst_ni,
    m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // One request at a time: busy right after a request is taken
  `HODT_ASSERT_NEXT(a_busy_after_request, clk_i, rst_ni,
    s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // Only a stored insert can record a persistent id
  `HODT_ASSERT_IMPLY(a_recorded_on_insert, clk_i, rst_ni,
    m_axis_tvalid && m_axis_tdata[96],
    m_axis_tuser == hodt_pkg::STAT_NEW || m_axis_tuser == hodt_pkg::STAT_OVERWRITTEN)

  // Slot contents leave the block only on a found lookup
  `HODT_ASSERT_IMPLY(a_found_fields_clear, clk_i, rst_ni,
    m_axis_tvalid && m_axis_tuser != hodt_pkg::STAT_FOUND, m_axis_tdata[95:8] == '0)

endmodule

bind hashed_object_dictionary_table hodt_checker u_hodt_checker (.*);
